FILE: rtl/core/sdp_pkg.sv
package sdp_pkg;

  // Character codes
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Magnitude bounds: 2^63-1 for positive, 2^63 for negative values
  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  // Result status codes; ST_OK also means "no error yet" in the sticky error register
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_SIGN_ONLY = 3'd2,
    ST_BAD_ZERO  = 3'd3,
    ST_NON_DIGIT = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  // One input beat
  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_byte;
    logic       is_last;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic signed [63:0] parsed_value;
    status_t            parse_status;
  } result_t;

endpackage

FILE: rtl/core/sdp_in_stage.sv
module sdp_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  sdp_pkg::in_beat_t in_beat,
  output logic             in_ready,
  input  logic             take,
  output logic             beat_valid,
  output sdp_pkg::in_beat_t beat
);
  import sdp_pkg::*;

  // Room for a new beat when empty or when the held beat moves on this cycle
  assign in_ready = ~beat_valid | take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (in_ready) begin
      beat_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat <= in_beat;
    end
  end

endmodule

FILE: rtl/core/sdp_accum.sv
module sdp_accum (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  sdp_pkg::in_beat_t beat,
  output logic              res_valid,
  output sdp_pkg::result_t  res
);
  import sdp_pkg::*;

  logic        at_start, at_start_next;
  logic        is_negative, is_negative_next;
  logic        digit_seen, digit_seen_next;
  logic        leading_zero, leading_zero_next;
  logic [63:0] magnitude, magnitude_next;
  status_t     error_code, error_code_next;

  logic [7:0]  digit_diff;
  logic [3:0]  digit;
  logic        is_digit;
  logic        is_zero;
  logic [67:0] mag_wide;
  logic [67:0] product;
  logic [63:0] limit;
  logic        fits;

  // Digit decode
  assign digit_diff = beat.char_byte - CHAR_ZERO;
  assign digit      = digit_diff[3:0];
  assign is_digit   = (beat.char_byte >= CHAR_ZERO) && (beat.char_byte <= CHAR_NINE);
  assign is_zero    = (beat.char_byte == CHAR_ZERO);

  // magnitude * 10 + digit as 8m + 2m + d, checked against the signed bound
  assign mag_wide = {4'd0, magnitude};
  assign product  = (mag_wide << 3) + (mag_wide << 1) + {64'd0, digit};
  assign limit    = is_negative ? NEG_LIMIT : POS_LIMIT;
  assign fits     = (product <= {4'd0, limit});

  // Next state for one byte
  always_comb begin
    at_start_next     = at_start;
    is_negative_next  = is_negative;
    digit_seen_next   = digit_seen;
    leading_zero_next = leading_zero;
    magnitude_next    = magnitude;
    error_code_next   = error_code;
    if (beat.has_byte && (error_code == ST_OK)) begin
      at_start_next = 1'b0;
      if (at_start && (beat.char_byte == CHAR_MINUS)) begin
        is_negative_next = 1'b1;
      end else if (leading_zero) begin
        error_code_next = ST_BAD_ZERO;
      end else if (!digit_seen && is_zero && is_negative) begin
        // "-0" is never canonical
        error_code_next = ST_BAD_ZERO;
      end else begin
        if (!digit_seen && is_zero) begin
          leading_zero_next = 1'b1;
        end
        if (!is_digit) begin
          error_code_next = ST_NON_DIGIT;
        end else if (!fits) begin
          error_code_next = ST_OVERFLOW;
        end else begin
          magnitude_next  = product[63:0];
          digit_seen_next = 1'b1;
        end
      end
    end
  end

  // Result from the updated state
  assign res_valid = take & beat.is_last;

  always_comb begin
    res.parsed_value = 64'sd0;
    if (error_code_next != ST_OK) begin
      res.parse_status = error_code_next;
    end else if (at_start_next) begin
      res.parse_status = ST_EMPTY;
    end else if (!digit_seen_next) begin
      res.parse_status = ST_SIGN_ONLY;
    end else begin
      res.parse_status = ST_OK;
      res.parsed_value = is_negative_next ? $signed(64'd0 - magnitude_next)
                                          : $signed(magnitude_next);
    end
  end

  // Parse state; cleared at reset and after every last beat
  always_ff @(posedge clk) begin
    if (rst || (take && beat.is_last)) begin
      at_start     <= 1'b1;
      is_negative  <= 1'b0;
      digit_seen   <= 1'b0;
      leading_zero <= 1'b0;
      magnitude    <= 64'd0;
      error_code   <= ST_OK;
    end else if (take) begin
      at_start     <= at_start_next;
      is_negative  <= is_negative_next;
      digit_seen   <= digit_seen_next;
      leading_zero <= leading_zero_next;
      magnitude    <= magnitude_next;
      error_code   <= error_code_next;
    end
  end

endmodule

FILE: rtl/core/sdp_out_stage.sv
module sdp_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sdp_pkg::result_t res,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_ready,
  output sdp_pkg::result_t out_res
);
  import sdp_pkg::*;

  // Slot can take a result when empty or when the held beat leaves now
  assign out_free = ~out_valid | out_ready;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

FILE: rtl/core/strict_decimal_to_i64_parser.sv
// Strict decimal string to signed 64-bit integer parser.
//
// Input stream (s_axis): one beat per string byte. tdata[7:0] is the byte,
// tuser[0] says the byte is present (0 for a bare end marker), tlast ends
// the string. An optional leading '-' is allowed; digits must be canonical.
// Output stream (m_axis): one beat per string, after its tlast beat.
// tdata is the signed value (zero unless ok), tuser[2:0] the status:
// ok, empty, sign only, non-canonical zero, non-digit byte, overflow.
//
// Throughput: one beat per cycle, except that a last beat waits while the
// result slot is busy. The limit is the combinational multiply-by-ten, add
// and bound compare on the magnitude register. A tlast beat passes the
// input register, then the result register, before m_axis_tvalid rises.
// When the receiver stalls, the held result stays put and non-last bytes
// are still taken; a last beat waits in the input register, holding tready
// low, until the result slot frees. Reset clears both registers and the
// parse state; tready is low while rst is high.
module strict_decimal_to_i64_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] parsed_value
  output logic [2:0]  m_axis_tuser    // [2:0] parse_status
);
  import sdp_pkg::*;

  in_beat_t in_beat;
  in_beat_t beat;
  logic     in_ready;
  logic     beat_valid;
  logic     take;
  logic     res_valid;
  result_t  res;
  result_t  out_res;
  logic     out_free;

  assign in_beat.char_byte = s_axis_tdata;
  assign in_beat.has_byte  = s_axis_tuser;
  assign in_beat.is_last   = s_axis_tlast;
  assign s_axis_tready     = ~rst & in_ready;

  // A held beat moves on unless it ends a string and the result slot is busy
  assign take = beat_valid & (~beat.is_last | out_free);

  sdp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid & ~rst),
    .in_beat    (in_beat),
    .in_ready   (in_ready),
    .take       (take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  sdp_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  sdp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = out_res.parsed_value;
  assign m_axis_tuser = out_res.parse_status;

endmodule

FILE: rtl/core/sdp_checker.sv
module sdp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import sdp_pkg::*;

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Failed parses carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == 64'd0))
    else $error("nonzero value with error status");

  // A fresh result into an empty slot comes from an input beat that passed the input register, then the result register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching input beat");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind strict_decimal_to_i64_parser sdp_checker u_sdp_checker (.*);

FILE: tb/sv/strict_decimal_to_i64_parser_tb.sv
`timescale 1ns / 1ps

module strict_decimal_to_i64_parser_tb;
  import sdp_pkg::*;

  typedef logic [7:0] char_q_t[$];

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // Input stream
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] char_byte
  logic        s_axis_tuser  = 1'b0;   // [0] has_byte
  logic        s_axis_tlast  = 1'b0;

  // Output stream
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;           // [63:0] parsed_value
  logic [2:0]  m_axis_tuser;           // [2:0] parse_status

  // Traffic shaping, in percent of cycles
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  // Bookkeeping
  int      mismatch_count = 0;
  int      items_sent     = 0;
  result_t number_q[$];

  // Parser model state
  logic        m_at_start;
  logic        m_negative;
  logic        m_digit_seen;
  logic        m_lead_zero;
  logic [63:0] m_magnitude;
  status_t     m_error;

  strict_decimal_to_i64_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk = ~clk;

  // Receiver backpressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic clear_parse();
    m_at_start   = 1'b1;
    m_negative   = 1'b0;
    m_digit_seen = 1'b0;
    m_lead_zero  = 1'b0;
    m_magnitude  = 64'd0;
    m_error      = ST_OK;
  endtask

  // Update the parse state with one accepted beat; queue a number on tlast
  task automatic accumulate_char(input logic [7:0] ch, input logic has, input logic last);
    logic [63:0] digit;
    logic [63:0] bound;
    logic        sign_taken;
    result_t     want;
    sign_taken = 1'b0;
    if (has && m_error == ST_OK) begin
      if (m_at_start) begin
        m_at_start = 1'b0;
        if (ch == CHAR_MINUS) begin
          m_negative = 1'b1;
          sign_taken = 1'b1;
        end
      end
      if (!sign_taken) begin
        if (m_lead_zero) begin
          m_error = ST_BAD_ZERO;
        end else if (!m_digit_seen && ch == CHAR_ZERO && m_negative) begin
          m_error = ST_BAD_ZERO;
        end else if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
          m_error = ST_NON_DIGIT;
        end else begin
          if (!m_digit_seen && ch == CHAR_ZERO) m_lead_zero = 1'b1;
          digit = {56'd0, ch - CHAR_ZERO};
          bound = m_negative ? NEG_LIMIT : POS_LIMIT;
          // bound test before the multiply-accumulate
          if (m_magnitude > (bound - digit) / 64'd10) begin
            m_error = ST_OVERFLOW;
          end else begin
            m_magnitude  = m_magnitude * 64'd10 + digit;
            m_digit_seen = 1'b1;
          end
        end
      end
    end
    if (last) begin
      want.parsed_value = 64'sd0;
      if (m_error != ST_OK) begin
        want.parse_status = m_error;
      end else if (m_at_start) begin
        want.parse_status = ST_EMPTY;
      end else if (!m_digit_seen) begin
        want.parse_status = ST_SIGN_ONLY;
      end else begin
        want.parse_status = ST_OK;
        want.parsed_value = m_negative ? 64'd0 - m_magnitude : m_magnitude;
      end
      number_q.insert(number_q.size(), want);
      clear_parse();
    end
  endtask

  // Drive one beat and hold it until accepted; tvalid stays high on return
  task automatic send_beat(input logic [7:0] ch, input logic has, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= has;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    accumulate_char(ch, has, last);
    items_sent++;
  endtask

  // One string; the end is either on the final byte or a bare end marker
  task automatic send_chars(input char_q_t chars, input bit bare_end);
    foreach (chars[i]) begin
      if ($urandom_range(19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(chars[i], 1'b1, (i == chars.size() - 1) && !bare_end);
    end
    if (bare_end || chars.size() == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic send_text(input string txt, input bit bare_end);
    char_q_t chars;
    for (int i = 0; i < txt.len(); i++) chars.insert(chars.size(), txt[i]);
    send_chars(chars, bare_end);
  endtask

  // Hold off the sender until every queued number has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (number_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random_string();
    char_q_t chars;
    char_q_t noise;
    string   bound_txt;
    int      kind;
    int      len;
    int      k;
    bound_txt = "922337203685477580";
    kind = $urandom_range(99);
    if (kind < 60) begin
      // canonical number, mostly short
      if ($urandom_range(1)) chars.insert(chars.size(), CHAR_MINUS);
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 1) : $urandom_range(6, 1);
      chars.insert(chars.size(), 8'(CHAR_ZERO + $urandom_range(9, 1)));
      for (int i = 1; i < len; i++)
        chars.insert(chars.size(), 8'(CHAR_ZERO + $urandom_range(9)));
    end else if (kind < 70) begin
      // around the int64 bounds
      if ($urandom_range(1)) chars.insert(chars.size(), CHAR_MINUS);
      for (int i = 0; i < bound_txt.len(); i++) chars.insert(chars.size(), bound_txt[i]);
      chars.insert(chars.size(), 8'(CHAR_ZERO + $urandom_range(9)));
      k = $urandom_range(3);
      for (int i = 0; i < k; i++) chars[chars.size() - 1 - i] = 8'(CHAR_ZERO + $urandom_range(9));
      if ($urandom_range(5) == 0) chars.insert(chars.size(), 8'(CHAR_ZERO + $urandom_range(9)));
    end else if (kind < 80) begin
      // zero and sign forms
      case ($urandom_range(3))
        0: chars.insert(chars.size(), CHAR_ZERO);
        1: begin
          chars.insert(chars.size(), CHAR_MINUS);
          chars.insert(chars.size(), CHAR_ZERO);
          if ($urandom_range(1)) chars.insert(chars.size(), 8'(CHAR_ZERO + $urandom_range(9)));
        end
        2: begin
          chars.insert(chars.size(), CHAR_ZERO);
          chars.insert(chars.size(),
                       ($urandom_range(1)) ? 8'(CHAR_ZERO + $urandom_range(9)) : 8'($urandom));
        end
        default: begin
          chars.insert(chars.size(), CHAR_MINUS);
          if ($urandom_range(1)) chars.insert(chars.size(), CHAR_MINUS);
        end
      endcase
    end else if (kind < 90) begin
      // number broken by one arbitrary byte
      len = $urandom_range(6, 1);
      for (int i = 0; i < len; i++)
        chars.insert(chars.size(), 8'(CHAR_ZERO + $urandom_range(9, 1)));
      chars.insert($urandom_range(len), 8'($urandom));
    end else begin
      // raw noise
      len = $urandom_range(8);
      for (int i = 0; i < len; i++) noise.insert(noise.size(), 8'($urandom));
      chars = noise;
    end
    send_chars(chars, 1'($urandom_range(1)));
  endtask

  task automatic test_special_strings();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_text("", 1'b1);
    send_beat(8'hA5, 1'b0, 1'b0);   // bare beat is ignored
    send_beat(8'h5A, 1'b0, 1'b1);
    send_text("-", 1'b0);
    send_text("0", 1'b1);
    send_text("-0", 1'b0);
    send_text("00", 1'b0);
    send_text("0x", 1'b1);
    send_text("7", 1'b0);
    send_text("-5", 1'b1);
    send_text("--1", 1'b0);
    send_text("1-", 1'b0);
    send_text("/", 1'b0);
    send_text(":", 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_int64_limits();
    send_text("9223372036854775807", 1'b0);
    send_text("9223372036854775808", 1'b1);
    send_text("-9223372036854775808", 1'b0);
    send_text("-9223372036854775809", 1'b1);
    send_text("99999999999999999999", 1'b0);   // sticky overflow
    send_text("1a99999999999999999999", 1'b1); // sticky non-digit
    wait_drained();
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
    int stop_at;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_string();
    wait_drained();
  endtask

  // Compare each output beat against the oldest queued number
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (number_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d status=%0d",
                                  $signed(m_axis_tdata), m_axis_tuser));
      end else begin
        want = number_q.pop_front();
        if (m_axis_tdata !== want.parsed_value)
          report_mismatch($sformatf("parsed_value got %0d want %0d",
                                    $signed(m_axis_tdata), want.parsed_value));
        if (m_axis_tuser !== want.parse_status)
          report_mismatch($sformatf("parse_status got %0d want %0d",
                                    m_axis_tuser, want.parse_status));
      end
    end
  end

  initial begin
    clear_parse();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_special_strings();
    test_int64_limits();
    test_random_traffic(0, 0, 290);
    test_random_traffic(81, 0, 290);
    test_random_traffic(0, 81, 290);
    test_random_traffic(36, 36, 290);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && number_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sdp_pkg.sv
rtl/core/sdp_in_stage.sv
rtl/core/sdp_accum.sv
rtl/core/sdp_out_stage.sv
rtl/core/strict_decimal_to_i64_parser.sv
rtl/core/sdp_checker.sv
tb/sv/strict_decimal_to_i64_parser_tb.sv
